### hw/rtl/idct_pkg.sv
// ----------------------------------------------------------------------------
// idct_pkg
// Shared constants and the cosine weight table of the 2-D inverse DCT.
// ----------------------------------------------------------------------------
package idct_pkg;

    localparam int SIZE      = 8;
    localparam int IDX_W     = $clog2(SIZE);
    localparam int AREA      = SIZE * SIZE;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int COEF_W    = 12;
    localparam int WEIGHT_W  = 15;
    localparam int ROW_W     = COEF_W + WEIGHT_W + IDX_W;
    localparam int ACC_W     = ROW_W + WEIGHT_W + IDX_W;
    localparam int QDEPTH    = 2;

    // Weight W[k][n] = round(2^13 * C(k) * cos((2n+1) k pi / 2N)), N = 8.
    function automatic logic signed [WEIGHT_W-1:0] weight(
        input logic [IDX_W-1:0] k,
        input logic [IDX_W-1:0] n
    );
        logic [5:0]  j;
        logic signed [WEIGHT_W-1:0] q;
        logic signed [WEIGHT_W-1:0] r;
        j = 6'((({3'd0, n} << 1) + 6'd1) * {3'd0, k});
        j = j & 6'(4 * SIZE - 1);
        r = '0;
        q = '0;
        if (k == '0)
        begin
            r = 15'sd5793;
        end
        else
        begin
            case (j[3] ? 6'(16 - {2'b0, j[3:0]}) & 6'd15 : {2'b0, j[3:0]})
                6'd0:    q = 15'sd8192;
                6'd1:    q = 15'sd8035;
                6'd2:    q = 15'sd7568;
                6'd3:    q = 15'sd6811;
                6'd4:    q = 15'sd5793;
                6'd5:    q = 15'sd4551;
                6'd6:    q = 15'sd3135;
                6'd7:    q = 15'sd1598;
                default: q = 15'sd0;
            endcase
            if (j[3:0] == 4'd8)
            begin
                q = 15'sd0;
            end
            // Quadrants 2 and 3 of the cosine are negative.
            r = (j[4] ^ j[3]) && (j[3:0] != 4'd8) ? -q : q;
            if (j[4:0] == 5'd16 || (j[3:0] == 4'd8))
            begin
                r = (j[4:0] == 5'd16) ? -15'sd8192 : 15'sd0;
            end
            if (j[4:0] == 5'd0)
            begin
                r = 15'sd8192;
            end
        end
        return r;
    endfunction

endpackage

### hw/rtl/idct_front.sv
// ----------------------------------------------------------------------------
// idct_front
// Collects coefficients of a block and queues a job when the block is full.
// ----------------------------------------------------------------------------
module idct_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [idct_pkg::COEF_W-1:0] in_coef,
    output logic                               wr_en,
    output logic                               wr_bank,
    output logic [idct_pkg::ADDR_W-1:0]        wr_addr,
    output logic signed [idct_pkg::COEF_W-1:0] wr_data,
    output logic                               job_valid,
    output logic                               job_bank,
    input  logic                               job_taken
);
    import idct_pkg::*;

    logic [ADDR_W-1:0] count_reg, count_next;
    logic              bank_reg, bank_next;
    logic [1:0]        pend_reg, pend_next;   // jobs queued, not done
    logic              head_reg, head_next;
    logic              acc;
    logic              done;

    // Two banks; loading stops while both hold unprocessed blocks.
    assign in_ready = (pend_reg != 2'(QDEPTH));
    assign acc      = in_valid && in_ready;
    assign done     = acc && (count_reg == ADDR_W'(AREA - 1));
    assign wr_en    = acc;
    assign wr_bank  = bank_reg;
    assign wr_addr  = count_reg;
    assign wr_data  = in_coef;
    assign job_valid = (pend_reg != 2'd0);
    assign job_bank  = head_reg;

    always_comb
    begin
        count_next = acc ? (done ? '0 : count_reg + 1'b1) : count_reg;
        bank_next  = done ? ~bank_reg : bank_reg;
        pend_next  = pend_reg + 2'(done) - 2'(job_taken);
        head_next  = job_taken ? ~head_reg : head_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            bank_reg  <= 1'b0;
            pend_reg  <= '0;
            head_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            bank_reg  <= bank_next;
            pend_reg  <= pend_next;
            head_reg  <= head_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) pend_reg <= 2'(QDEPTH))
        else $error("job count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) job_taken |-> job_valid)
        else $error("job taken while none queued");
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (count_reg == '0)) else $error("count not wrapped");
endmodule

### hw/rtl/idct_back.sv
// ----------------------------------------------------------------------------
// idct_back
// Two-pass separable inverse DCT with one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
module idct_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic                               wr_bank,
    input  logic [idct_pkg::ADDR_W-1:0]        wr_addr,
    input  logic signed [idct_pkg::COEF_W-1:0] wr_data,
    input  logic                               job_valid,
    input  logic                               job_bank,
    output logic                               job_taken,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         out_pixel,
    output logic                               out_last
);
    import idct_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ROW  = 4'b0010,
        S_COL  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic signed [COEF_W-1:0] coef_mem [2*AREA];
    logic signed [ROW_W-1:0]  tmp_mem [AREA];      // T[v][x] = sum_u W[u][x] S[v][u]
    logic signed [COEF_W-1:0] coef_rd;
    logic signed [ROW_W-1:0]  tmp_rd;
    logic [IDX_W-1:0] a_reg, b_reg, c_reg;         // outer, middle, inner indices
    logic [IDX_W-1:0] a_next, b_next, c_next;
    logic             bank_reg;
    logic             rd_ok_reg;                   // read data valid for MAC
    logic [IDX_W-1:0] wa_reg, wb_reg;              // indices of the pending MAC
    logic             wlast_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic             prod_ok_reg, plast_reg;
    logic [IDX_W-1:0] sa_reg, sb_reg;
    logic [IDX_W-1:0] pa_reg, pb_reg;
    logic signed [WEIGHT_W-1:0] wt;
    logic signed [ROW_W-1:0] mac_in;
    logic signed [ROW_W+WEIGHT_W-1:0] prod_full;
    logic signed [ACC_W-1:0] mul;
    logic signed [ACC_W-1:0] sum;
    logic [7:0]       pix;
    logic             fin;
    logic             out_full_reg;
    logic [7:0]       pix_reg;
    logic             last_reg;
    logic             issue;
    logic [ACC_W-1:0] q;
    logic             fin_hold_reg;
    logic             col_mode_reg;

    assign issue = (state_reg == S_ROW || state_reg == S_COL);

    // Row pass: a = v, b = x, c = u. Column pass: a = y, b = x, c = v.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            coef_mem[{wr_bank, wr_addr}] <= wr_data;
        end
        coef_rd <= coef_mem[{bank_reg, a_reg, c_reg}];
        tmp_rd  <= tmp_mem[{c_reg, b_reg}];
        if (fin && !col_mode_reg)
        begin
            tmp_mem[{pa_reg, pb_reg}] <= sum[ROW_W-1:0];
        end
    end

    // The pass flag stays put until the pipe has drained, unlike the state.
    always_comb
    begin
        wt        = weight(wa_reg, wb_reg);
        mac_in    = col_mode_reg ? tmp_rd : ROW_W'(coef_rd);
        prod_full = wt * mac_in;
        mul       = ACC_W'(prod_full);
    end

    assign fin = prod_ok_reg && plast_reg;
    assign sum = acc_reg + prod_reg;

    // Round half away from zero; only positive sums matter after clamp.
    always_comb
    begin
        q   = ACC_W'((sum + ACC_W'(64'd1 << 27)) >>> 28);
        pix = (sum <= 0) ? 8'd0 : ((q > ACC_W'(255)) ? 8'd255 : q[7:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        job_taken = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = S_ROW;
                    a_next = '0;
                    b_next = '0;
                    c_next = '0;
                end
            end
            S_ROW, S_COL:
            begin
                c_next = c_reg + 1'b1;
                if (c_reg == IDX_W'(SIZE - 1))
                begin
                    b_next = b_reg + 1'b1;
                    if (b_reg == IDX_W'(SIZE - 1))
                    begin
                        a_next = a_reg + 1'b1;
                        if (a_reg == IDX_W'(SIZE - 1))
                        begin
                            state_next = S_OUT;
                        end
                    end
                    if (state_reg == S_COL)
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                // Wait for the MAC pipe to drain and the pixel to leave.
                if (!rd_ok_reg && !prod_ok_reg && !fin_hold_reg && !out_full_reg)
                begin
                    if (col_mode_reg && a_reg == '0 && b_reg == '0)
                    begin
                        state_next = S_IDLE;
                        job_taken  = 1'b1;
                    end
                    else
                    begin
                        state_next = S_COL;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rd_ok_reg    <= 1'b0;
            prod_ok_reg  <= 1'b0;
            out_full_reg <= 1'b0;
            fin_hold_reg <= 1'b0;
            col_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_ok_reg   <= issue;
            prod_ok_reg <= rd_ok_reg;
            fin_hold_reg <= fin;
            if (state_reg == S_IDLE && job_valid)
            begin
                col_mode_reg <= 1'b0;
            end
            else if (state_reg == S_OUT && state_next == S_COL)
            begin
                col_mode_reg <= 1'b1;
            end
            if (fin && col_mode_reg)
            begin
                out_full_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        if (state_reg == S_IDLE)
        begin
            bank_reg <= job_bank;
        end
        if (col_mode_reg || state_reg == S_COL)
        begin
            wa_reg <= c_reg;
            wb_reg <= a_reg;
        end
        else
        begin
            wa_reg <= c_reg;
            wb_reg <= b_reg;
        end
        wlast_reg <= (c_reg == IDX_W'(SIZE - 1));
        sa_reg    <= a_reg;
        sb_reg    <= b_reg;
        pa_reg    <= sa_reg;
        pb_reg    <= sb_reg;
        prod_reg  <= mul;
        plast_reg <= wlast_reg;
        if (prod_ok_reg)
        begin
            acc_reg <= fin ? '0 : sum;
        end
        else
        begin
            acc_reg <= '0;
        end
        if (fin && col_mode_reg)
        begin
            pix_reg  <= pix;
            last_reg <= (pa_reg == IDX_W'(SIZE - 1)) && (pb_reg == IDX_W'(SIZE - 1));
        end
    end

    assign out_valid = out_full_reg;
    assign out_pixel = pix_reg;
    assign out_last  = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("pixel dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        job_taken |-> (state_reg == S_OUT)) else $error("job release out of order");
endmodule

### hw/rtl/idct_2d_clamped_pixels.sv
// ----------------------------------------------------------------------------
// idct_2d_clamped_pixels
// 8x8 inverse DCT producing rounded, clamped 8-bit pixels.
// ----------------------------------------------------------------------------
// Usage: coefficients enter on the s_axis channel, one 12-bit signed value per
// transfer, raster order. After the 64th transfer of a block, the back end
// runs a row pass (512 MACs) and then a column pass (512 MACs), emitting each
// pixel on m_axis as it is finished; tlast marks the 64th pixel.
// One shared multiplier sets the rate. The row pass is followed by a drain
// of the MAC pipe; each pixel then takes eight MACs, followed by a drain and
// the handoff of the pixel, and the back end takes no new block until the
// last pixel of the current one has been taken.
// Two coefficient banks let the next block load while the previous one is
// transformed. s_axis_tready drops only when both banks hold unprocessed
// blocks.
// When m_axis_tready is low the back end holds the pixel and pauses, and
// every stall lengthens the time spent on the block.
// Reset marks both banks empty, clears the queue and returns the back end to idle.
// ----------------------------------------------------------------------------
module idct_2d_clamped_pixels (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] coefficient
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] pixel
    output logic        m_axis_tlast
);
    import idct_pkg::*;

    logic              wr_en, wr_bank, job_valid, job_bank, job_taken;
    logic [ADDR_W-1:0] wr_addr;
    logic signed [COEF_W-1:0] wr_data;

    idct_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_coef(s_axis_tdata[COEF_W-1:0]),
        .wr_en(wr_en), .wr_bank(wr_bank), .wr_addr(wr_addr), .wr_data(wr_data),
        .job_valid(job_valid), .job_bank(job_bank), .job_taken(job_taken)
    );

    idct_back u_back (
        .clk(clk), .rst_n(rst_n),
        .wr_en(wr_en), .wr_bank(wr_bank), .wr_addr(wr_addr), .wr_data(wr_data),
        .job_valid(job_valid), .job_bank(job_bank), .job_taken(job_taken),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_pixel(m_axis_tdata), .out_last(m_axis_tlast)
    );
endmodule
